// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

   // sequencer phases
   localparam logic [4:0] PH_IDLE       = 5'd0;
   localparam logic [4:0] PH_START      = 5'd1;
   localparam logic [4:0] PH_STOP       = 5'd2;
   localparam logic [4:0] PH_SEND_SET   = 5'd3;
   localparam logic [4:0] PH_SEND_HIGH  = 5'd4;
   localparam logic [4:0] PH_SEND_LOW   = 5'd5;
   localparam logic [4:0] PH_WAIT_SETUP = 5'd6;
   localparam logic [4:0] PH_WAIT_POLL  = 5'd7;
   localparam logic [4:0] PH_READ_LOW   = 5'd8;
   localparam logic [4:0] PH_READ_HIGH  = 5'd9;
   localparam logic [4:0] PH_ACK_LOW    = 5'd10;
   localparam logic [4:0] PH_ACK_HIGH   = 5'd11;

   // command codes on func
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_SEND  = 3'd2;
   localparam logic [2:0] CMD_WAIT  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [7:0] TIMEOUT_RESET = 8'd250;
   localparam logic [3:0] BYTE_BITS     = 4'd8;

   // sequencer state carried from tick to tick
   typedef struct packed {
      logic [4:0] phase;
      logic [2:0] cmd;
      logic [3:0] bit_index;
      logic [7:0] shift_data;
      logic [7:0] poll_count;
      logic       scl;
      logic       sda;
      logic       ack_choice;
      logic       fail;
      logic [7:0] rx_hold;
   } seq_state_type;

   // one tick's result
   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       cmd_done;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } tick_result_type;

endpackage

// ----- rtl/i2cm_step.sv -----
module i2cm_step
   import i2cm_pkg::*;
(
   input  seq_state_type   cur_state,
   input  logic [7:0]      ack_timeout,
   input  logic            cmd_valid,
   input  logic [2:0]      func,
   input  logic [7:0]      tx_byte,
   input  logic            send_ack,
   input  logic            sda_sample,
   output seq_state_type   next_state,
   output tick_result_type result
);

   always_comb begin
      seq_state_type s;
      logic [4:0]    nxt;
      logic          busy;
      logic          done;
      logic          scl_low_after;
      logic [8:0]    cnt;

      s             = cur_state;
      busy          = 1'b0;
      done          = 1'b0;
      scl_low_after = 1'b0;
      cnt           = {1'b0, s.poll_count} + 9'd1;

      // command capture while idle; unknown codes are dropped
      if (s.phase == PH_IDLE && cmd_valid && func <= CMD_READ) begin
         s.cmd        = func;
         s.bit_index  = 4'd0;
         s.poll_count = 8'd0;
         case (func)
            CMD_START: s.phase = PH_START;
            CMD_STOP:  s.phase = PH_STOP;
            CMD_SEND: begin
               s.phase      = PH_SEND_SET;
               s.shift_data = tx_byte;
            end
            CMD_WAIT:  s.phase = PH_WAIT_SETUP;
            default: begin
               s.phase      = PH_READ_LOW;
               s.shift_data = 8'd0;
               s.ack_choice = send_ack;
            end
         endcase
      end

      busy = (s.phase != PH_IDLE);
      nxt  = s.phase;

      case (s.phase)
         PH_START: begin
            if (s.bit_index == 4'd0) s.sda = 1'b1;
            else if (s.bit_index == 4'd1) s.scl = 1'b1;
            else s.sda = 1'b0;
            if (s.bit_index >= 4'd2) begin
               done          = 1'b1;
               scl_low_after = 1'b1;
               nxt           = PH_IDLE;
            end else begin
               s.bit_index = s.bit_index + 4'd1;
            end
         end
         PH_STOP: begin
            if (s.bit_index == 4'd0) s.scl = 1'b0;
            else if (s.bit_index == 4'd1) s.sda = 1'b0;
            else if (s.bit_index == 4'd2) s.scl = 1'b1;
            else s.sda = 1'b1;
            if (s.bit_index >= 4'd3) begin
               done = 1'b1;
               if (s.cmd == CMD_WAIT) s.fail = 1'b1;
               nxt = PH_IDLE;
            end else begin
               s.bit_index = s.bit_index + 4'd1;
            end
         end
         PH_SEND_SET: begin
            s.scl        = 1'b0;
            s.sda        = s.shift_data[7];
            s.shift_data = {s.shift_data[6:0], 1'b0};
            nxt          = PH_SEND_HIGH;
         end
         PH_SEND_HIGH: begin
            s.scl = 1'b1;
            nxt   = PH_SEND_LOW;
         end
         PH_SEND_LOW: begin
            s.scl       = 1'b0;
            s.bit_index = s.bit_index + 4'd1;
            if (s.bit_index >= BYTE_BITS) begin
               done = 1'b1;
               nxt  = PH_IDLE;
            end else begin
               nxt = PH_SEND_SET;
            end
         end
         PH_WAIT_SETUP: begin
            s.sda = 1'b1;
            if (s.bit_index == 4'd0) begin
               s.bit_index = 4'd1;
            end else begin
               s.scl        = 1'b1;
               s.poll_count = 8'd0;
               nxt          = PH_WAIT_POLL;
            end
         end
         PH_WAIT_POLL: begin
            s.scl = 1'b1;
            s.sda = 1'b1;
            if (!sda_sample) begin
               done          = 1'b1;
               s.fail        = 1'b0;
               scl_low_after = 1'b1;
               nxt           = PH_IDLE;
            end else begin
               // 9-bit compare: a timeout of 255 still expires
               s.poll_count = cnt[7:0];
               if (cnt > {1'b0, ack_timeout}) begin
                  s.bit_index = 4'd0;
                  nxt         = PH_STOP;
               end
            end
         end
         PH_READ_LOW: begin
            s.scl = 1'b0;
            s.sda = 1'b1;
            nxt   = PH_READ_HIGH;
         end
         PH_READ_HIGH: begin
            s.scl        = 1'b1;
            s.sda        = 1'b1;
            s.shift_data = {s.shift_data[6:0], sda_sample};
            s.bit_index  = s.bit_index + 4'd1;
            if (s.bit_index >= BYTE_BITS) begin
               s.rx_hold = s.shift_data;
               nxt       = PH_ACK_LOW;
            end else begin
               nxt = PH_READ_LOW;
            end
         end
         PH_ACK_LOW: begin
            s.scl = 1'b0;
            s.sda = !s.ack_choice;
            nxt   = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            s.scl         = 1'b1;
            done          = 1'b1;
            scl_low_after = 1'b1;
            nxt           = PH_IDLE;
         end
         default: begin
            nxt  = PH_IDLE;
            busy = 1'b0;
         end
      endcase

      result.scl_level   = s.scl;
      result.sda_release = s.sda;
      result.busy_res    = busy;
      result.cmd_done    = done;
      result.rx_byte     = s.rx_hold;
      result.ack_failed  = s.fail;

      if (scl_low_after) s.scl = 1'b0;
      s.phase    = nxt;
      next_state = s;
   end

endmodule

// ----- rtl/i2c_master_byte_engine.sv -----
// I2C master line sequencer, one item per tick of the 4 us line timebase.
//
// Input channel (req_*): each item is one tick. It carries the sampled SDA
// level and, while the engine is idle, an optional command (start, stop,
// send byte, wait for ack, read byte with ACK/NACK). Commands offered while
// a sequence runs, and unknown func codes, are ignored.
// Result channel (rsp_*): exactly one item per input item, giving the SCL
// level and SDA release/drive for that tick, busy, done, the last read byte
// and the ack-failure flag.
// Config: csr_wr_en writes csr_wr_data into ack_timeout (reset 250); write
// only while no command is running.
//
// An item accepted at one edge has its result on rsp_* after that edge.
// Throughput is 1 item per cycle unless stalled; the whole tick update is
// one pass of combinational logic from the state register to the result
// register. req_ready is low only while a result waits and rsp_ready is low,
// so a stalled receiver holds the engine with its result intact.
// Reset (synchronous, active high) empties the result register, returns the
// sequencer to idle with SCL and SDA released high, and restores ack_timeout.
module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   // tick input
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd_valid,
   input  logic [2:0] req_func,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_ack,
   input  logic       req_sda_sample,
   // tick result
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_release,
   output logic       rsp_busy_res,
   output logic       rsp_cmd_done,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_failed
);

   localparam seq_state_type STATE_RESET = '{
      phase:      PH_IDLE,
      cmd:        CMD_START,
      bit_index:  4'd0,
      shift_data: 8'd0,
      poll_count: 8'd0,
      scl:        1'b1,
      sda:        1'b1,
      ack_choice: 1'b0,
      fail:       1'b0,
      rx_hold:    8'd0
   };

   seq_state_type   state_ff;
   seq_state_type   state_in;
   tick_result_type result_ff;
   tick_result_type result_in;
   logic [7:0]      timeout_ff;
   logic            rsp_valid_ff;
   logic            accept;

   // a new tick may enter whenever the result register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   i2cm_step u_step (
      .cur_state   (state_ff),
      .ack_timeout (timeout_ff),
      .cmd_valid   (req_cmd_valid),
      .func        (req_func),
      .tx_byte     (req_tx_byte),
      .send_ack    (req_send_ack),
      .sda_sample  (req_sda_sample),
      .next_state  (state_in),
      .result      (result_in)
   );

   // sequencer state and ack timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         if (accept) state_ff <= state_in;
         if (csr_wr_en) timeout_ff <= csr_wr_data;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, loaded only with a new tick
   always_ff @(posedge clock) begin
      if (accept) result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = result_ff.scl_level;
   assign rsp_sda_release = result_ff.sda_release;
   assign rsp_busy_res    = result_ff.busy_res;
   assign rsp_cmd_done    = result_ff.cmd_done;
   assign rsp_rx_byte     = result_ff.rx_byte;
   assign rsp_ack_failed  = result_ff.ack_failed;

endmodule

// ----- rtl/i2cm_checker.sv -----
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_level,
   input logic       rsp_sda_release,
   input logic       rsp_busy_res,
   input logic       rsp_cmd_done,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_ack_failed
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl_level)
         && $stable(rsp_sda_release) && $stable(rsp_busy_res)
         && $stable(rsp_cmd_done) && $stable(rsp_rx_byte) && $stable(rsp_ack_failed))
      else $error("result changed while stalled");

   // every accepted tick yields a result on the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick produced no result");

   // the engine only stalls behind a waiting result
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // done is only reported on a busy tick
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_done |-> rsp_busy_res)
      else $error("done without busy");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

// ----- bench/tb_i2c_master_byte_engine.sv -----
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine
   import i2cm_pkg::*;
;

   localparam int CLK_HALF     = 6;       // 12 ns clock
   localparam int RESET_CYCLES = 6;
   localparam int HOLD_CYCLES  = 80;      // long receiver hold-off
   localparam int CYCLE_LIMIT  = 200000;  // generous: ~1050 ticks, gaps, stalls
   localparam int RANDOM_ITEMS = 310;
   localparam int MAX_PRINTED  = 100;     // keep the log short on a broken block

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   logic       req_cmd_valid;
   logic [2:0] req_func;
   logic [7:0] req_tx_byte;
   logic       req_send_ack;
   logic       req_sda_sample;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_scl_level;
   logic       rsp_sda_release;
   logic       rsp_busy_res;
   logic       rsp_cmd_done;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_failed;

   i2c_master_byte_engine dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd_valid  (req_cmd_valid),
      .req_func       (req_func),
      .req_tx_byte    (req_tx_byte),
      .req_send_ack   (req_send_ack),
      .req_sda_sample (req_sda_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_release(rsp_sda_release),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_cmd_done   (rsp_cmd_done),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_failed (rsp_ack_failed)
   );

   // ---------------------------------------------------------------------
   // Engine state as the bench sees it, plus the ack timeout in force.
   // Updated at the edge where an item is taken; the sender reads it at the
   // following falling edge to shape the next item.
   // ---------------------------------------------------------------------
   seq_state_type   eng_st;
   logic [7:0]      timeout_now;
   tick_result_type expected_ticks[$];

   int  errors       = 0;
   int  results_seen = 0;
   int  items_sent   = 0;
   int  burst_left   = 0;
   bit  gaps_on      = 1'b1;
   bit  hold_req     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // hard stop if anything hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_i2c_master_byte_engine: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tick predictor: plays one 4 us tick of the line sequencer.
   // Line levels reported are the ones held during the tick; SCL may drop
   // right after the tick (end of start, ack seen, end of read).
   // ---------------------------------------------------------------------
   function automatic tick_result_type play_tick(input logic cv, input logic [2:0] fn,
                                                 input logic [7:0] tx, input logic ak,
                                                 input logic sd);
      tick_result_type res;
      logic [4:0]      nxt;
      logic            busy;
      logic            done;
      logic            scl_drop;
      logic [8:0]      polls;
      busy     = 1'b0;
      done     = 1'b0;
      scl_drop = 1'b0;

      // a new command is taken only while idle, and only a known code
      if (eng_st.phase == PH_IDLE && cv && fn <= CMD_READ) begin
         eng_st.cmd        = fn;
         eng_st.bit_index  = '0;
         eng_st.poll_count = '0;
         case (fn)
            CMD_START: eng_st.phase = PH_START;
            CMD_STOP:  eng_st.phase = PH_STOP;
            CMD_SEND: begin
               eng_st.phase      = PH_SEND_SET;
               eng_st.shift_data = tx;
            end
            CMD_WAIT:  eng_st.phase = PH_WAIT_SETUP;
            default: begin
               eng_st.phase      = PH_READ_LOW;
               eng_st.shift_data = '0;
               eng_st.ack_choice = ak;
            end
         endcase
      end

      busy = (eng_st.phase != PH_IDLE);
      nxt  = eng_st.phase;

      case (eng_st.phase)
         PH_START: begin
            if (eng_st.bit_index == 0)      eng_st.sda = 1'b1;
            else if (eng_st.bit_index == 1) eng_st.scl = 1'b1;
            else                            eng_st.sda = 1'b0;
            if (eng_st.bit_index >= 2) begin
               done     = 1'b1;
               scl_drop = 1'b1;
               nxt      = PH_IDLE;
            end else begin
               eng_st.bit_index++;
            end
         end
         PH_STOP: begin
            if (eng_st.bit_index == 0)      eng_st.scl = 1'b0;
            else if (eng_st.bit_index == 1) eng_st.sda = 1'b0;
            else if (eng_st.bit_index == 2) eng_st.scl = 1'b1;
            else                            eng_st.sda = 1'b1;
            if (eng_st.bit_index >= 3) begin
               done = 1'b1;
               // stop reached through an ack timeout flags the failure
               if (eng_st.cmd == CMD_WAIT) eng_st.fail = 1'b1;
               nxt = PH_IDLE;
            end else begin
               eng_st.bit_index++;
            end
         end
         PH_SEND_SET: begin
            eng_st.scl        = 1'b0;
            eng_st.sda        = eng_st.shift_data[7];
            eng_st.shift_data = {eng_st.shift_data[6:0], 1'b0};
            nxt               = PH_SEND_HIGH;
         end
         PH_SEND_HIGH: begin
            eng_st.scl = 1'b1;
            nxt        = PH_SEND_LOW;
         end
         PH_SEND_LOW: begin
            eng_st.scl = 1'b0;
            eng_st.bit_index++;
            if (eng_st.bit_index >= BYTE_BITS) begin
               done = 1'b1;
               nxt  = PH_IDLE;
            end else begin
               nxt = PH_SEND_SET;
            end
         end
         PH_WAIT_SETUP: begin
            eng_st.sda = 1'b1;
            if (eng_st.bit_index == 0) begin
               eng_st.bit_index = 4'd1;
            end else begin
               eng_st.scl        = 1'b1;
               eng_st.poll_count = '0;
               nxt               = PH_WAIT_POLL;
            end
         end
         PH_WAIT_POLL: begin
            eng_st.scl = 1'b1;
            eng_st.sda = 1'b1;
            if (!sd) begin
               done        = 1'b1;
               eng_st.fail = 1'b0;
               scl_drop    = 1'b1;
               nxt         = PH_IDLE;
            end else begin
               // count compared at 9 bits: timeout 255 still ends
               polls             = {1'b0, eng_st.poll_count} + 9'd1;
               eng_st.poll_count = polls[7:0];
               if (polls > {1'b0, timeout_now}) begin
                  eng_st.bit_index = '0;
                  nxt              = PH_STOP;
               end
            end
         end
         PH_READ_LOW: begin
            eng_st.scl = 1'b0;
            eng_st.sda = 1'b1;
            nxt        = PH_READ_HIGH;
         end
         PH_READ_HIGH: begin
            eng_st.scl        = 1'b1;
            eng_st.sda        = 1'b1;
            eng_st.shift_data = {eng_st.shift_data[6:0], sd};
            eng_st.bit_index++;
            if (eng_st.bit_index >= BYTE_BITS) begin
               eng_st.rx_hold = eng_st.shift_data;
               nxt            = PH_ACK_LOW;
            end else begin
               nxt = PH_READ_LOW;
            end
         end
         PH_ACK_LOW: begin
            eng_st.scl = 1'b0;
            eng_st.sda = ~eng_st.ack_choice;   // ACK pulls SDA low
            nxt        = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            eng_st.scl = 1'b1;
            done       = 1'b1;
            scl_drop   = 1'b1;
            nxt        = PH_IDLE;
         end
         default: begin
            nxt  = PH_IDLE;
            busy = 1'b0;
         end
      endcase

      res.scl_level   = eng_st.scl;
      res.sda_release = eng_st.sda;
      res.busy_res    = busy;
      res.cmd_done    = done;
      res.rx_byte     = eng_st.rx_hold;
      res.ack_failed  = eng_st.fail;

      if (scl_drop) eng_st.scl = 1'b0;
      eng_st.phase = nxt;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Reporting and checking
   // ---------------------------------------------------------------------
   task automatic report_error(input string msg);
      // count every error, print only the first batch
      if (errors < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
   endtask

   task automatic check_result();
      tick_result_type want;
      if (expected_ticks.size() == 0) begin
         report_error($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
         want = expected_ticks.pop_front();
         check_field("scl_level",   8'(rsp_scl_level),   8'(want.scl_level));
         check_field("sda_release", 8'(rsp_sda_release), 8'(want.sda_release));
         check_field("busy_res",    8'(rsp_busy_res),    8'(want.busy_res));
         check_field("cmd_done",    8'(rsp_cmd_done),    8'(want.cmd_done));
         check_field("rx_byte",     rsp_rx_byte,         want.rx_byte);
         check_field("ack_failed",  8'(rsp_ack_failed),  8'(want.ack_failed));
      end
      results_seen++;
   endtask

   // Both handshakes sampled at the rising edge. The result check runs
   // first; an item taken at this edge has its result on a later edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready)
            expected_ticks.push_back(play_tick(req_cmd_valid, req_func, req_tx_byte,
                                               req_send_ack, req_sda_sample));
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready follows a rotating 16-bit stall pattern, reloaded
   // once its 16 bits are used; some patterns never stall. A hold-off
   // request drops ready for a hold-off counted by HOLD_CYCLES.
   // ---------------------------------------------------------------------
   initial begin
      logic [15:0] stall_pat;
      int          pat_left;
      stall_pat = '1;
      pat_left  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (pat_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pat = '1;
                  1:       stall_pat = 16'($urandom);
                  default: stall_pat = 16'($urandom) | 16'($urandom);
               endcase
               pat_left = 16;
            end
            rsp_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_left--;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender. Called at a falling edge, returns at the falling edge after
   // the item was taken, with valid still high; whoever pauses lowers it.
   // Items go out in bursts with random gaps between bursts.
   // ---------------------------------------------------------------------
   task automatic send_tick(input logic cv, input logic [2:0] fn, input logic [7:0] tx,
                            input logic ak, input logic sd);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (gaps_on) gap = $urandom_range(0, 4);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd_valid  <= cv;
      req_func       <= fn;
      req_tx_byte    <= tx;
      req_send_ack   <= ak;
      req_sda_sample <= sd;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // One command from idle back to idle. SDA samples follow the line:
   // during ack polls the first high_polls samples are high, then low;
   // during read bits the sample is the matching bit of rx_bits. Elsewhere
   // SDA is random. With noisy set, stray commands are offered while busy.
   task automatic run_cmd(input logic [2:0] fn, input logic [7:0] tx, input logic ak,
                          input int high_polls, input logic [7:0] rx_bits, input bit noisy);
      int   highs;
      logic sd;
      highs = 0;
      send_tick(1'b1, fn, tx, ak, 1'($urandom_range(0, 1)));
      while (eng_st.phase != PH_IDLE) begin
         sd = 1'($urandom_range(0, 1));
         if (eng_st.phase == PH_WAIT_POLL) begin
            sd = (highs < high_polls);
            if (sd) highs++;
         end else if (eng_st.phase == PH_READ_HIGH) begin
            sd = rx_bits[7 - eng_st.bit_index];
         end
         send_tick(noisy && ($urandom_range(0, 3) == 0), 3'($urandom_range(0, 7)),
                   8'($urandom), 1'($urandom_range(0, 1)), sd);
      end
   endtask

   // Sender pause: nothing offered until every expected result is in.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // Timeout written only with the engine idle and nothing in flight.
   task automatic write_timeout(input logic [7:0] value);
      wait_results_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      timeout_now = value;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // idle ticks hold the lines; unknown func codes are dropped
   task automatic test_idle_and_unknown_codes();
      send_tick(1'b0, CMD_START, 8'h00, 1'b0, 1'b0);
      send_tick(1'b0, CMD_READ,  8'hFF, 1'b1, 1'b1);
      for (int code = 5; code <= 7; code++)
         run_cmd(3'(code), 8'($urandom), 1'($urandom_range(0, 1)), 0, 8'h00, 1'b0);
   endtask

   // reset value of the timeout: 251 high polls end in stop and failure
   task automatic test_reset_timeout();
      run_cmd(CMD_WAIT, 8'h00, 1'b0, int'(TIMEOUT_RESET) + 1, 8'h00, 1'b0);
   endtask

   // every command, byte extremes, ACK and NACK, stray commands while busy
   task automatic test_line_sequences();
      run_cmd(CMD_STOP,  8'h00, 1'b0, 0, 8'h00, 1'b0);
      run_cmd(CMD_START, 8'h00, 1'b0, 0, 8'h00, 1'b0);
      run_cmd(CMD_SEND,  8'h00, 1'b0, 0, 8'h00, 1'b0);
      run_cmd(CMD_WAIT,  8'h00, 1'b0, 0, 8'h00, 1'b0);   // acked on first poll
      run_cmd(CMD_SEND,  8'hFF, 1'b0, 0, 8'h00, 1'b1);
      run_cmd(CMD_WAIT,  8'h00, 1'b0, 2, 8'h00, 1'b1);
      run_cmd(CMD_SEND,  8'hA5, 1'b1, 0, 8'h00, 1'b0);
      run_cmd(CMD_READ,  8'h00, 1'b1, 0, 8'hFF, 1'b0);   // ACK
      run_cmd(CMD_READ,  8'hFF, 1'b0, 0, 8'h00, 1'b0);   // NACK
      run_cmd(CMD_READ,  8'h5A, 1'b1, 0, 8'h3C, 1'b1);
      run_cmd(CMD_START, 8'h00, 1'b0, 0, 8'h00, 1'b1);
      run_cmd(CMD_STOP,  8'h00, 1'b0, 0, 8'h00, 1'b0);
   endtask

   // timeout boundaries, including 255 where the count compares at 9 bits
   task automatic test_timeout_limits();
      write_timeout(8'd0);
      run_cmd(CMD_WAIT, 8'h00, 1'b0, 0, 8'h00, 1'b0);
      run_cmd(CMD_WAIT, 8'h00, 1'b0, 1, 8'h00, 1'b0);
      write_timeout(8'd3);
      run_cmd(CMD_WAIT, 8'h00, 1'b0, 3, 8'h00, 1'b0);
      run_cmd(CMD_WAIT, 8'h00, 1'b0, 4, 8'h00, 1'b0);
      write_timeout(8'd255);
      run_cmd(CMD_WAIT, 8'h00, 1'b0, 256, 8'h00, 1'b0);
      run_cmd(CMD_WAIT, 8'h00, 1'b0, 0, 8'h00, 1'b0);   // success clears failure
   endtask

   // receiver holds off while the sender keeps offering back to back,
   // then the sender pauses until everything has drained
   task automatic test_backpressure();
      gaps_on  = 1'b0;
      hold_req = 1'b1;
      run_cmd(CMD_SEND, 8'h96, 1'b0, 0, 8'h00, 1'b0);
      run_cmd(CMD_READ, 8'h00, 1'b0, 0, 8'hC3, 1'b1);
      wait_results_drained();
      gaps_on = 1'b1;
   endtask

   // mostly whole commands with random content; some idle ticks and
   // unknown codes; the timeout and sender idling change every 25 commands
   task automatic test_random_traffic(input int target);
      int first;
      int cmds;
      int pick;
      first = items_sent;
      cmds  = 0;
      while (items_sent - first < target) begin
         if (cmds % 25 == 0) begin
            write_timeout(8'($urandom_range(0, 8)));
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         cmds++;
         pick = $urandom_range(0, 99);
         if (pick < 6)
            send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else if (pick < 10)
            run_cmd(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                    0, 8'h00, 1'b0);
         else
            run_cmd(3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom_range(0, 1)),
                    $urandom_range(0, int'(timeout_now) + 2), 8'($urandom),
                    $urandom_range(0, 2) == 0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_valid      = 1'b0;
      req_cmd_valid  = 1'b0;
      req_func       = CMD_START;
      req_tx_byte    = '0;
      req_send_ack   = 1'b0;
      req_sda_sample = 1'b1;

      eng_st            = '0;
      eng_st.phase      = PH_IDLE;
      eng_st.scl        = 1'b1;
      eng_st.sda        = 1'b1;
      timeout_now       = TIMEOUT_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_and_unknown_codes();
      test_reset_timeout();
      test_line_sequences();
      test_timeout_limits();
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      wait_results_drained();
      repeat (4) @(negedge clock);
      if (errors == 0)
         $display("tb_i2c_master_byte_engine: done, clean");
      else
         $display("tb_i2c_master_byte_engine: done, errors");
      $finish;
   end

endmodule

// ----- i2c_master_byte_engine.f -----
rtl/i2cm_pkg.sv
rtl/i2cm_step.sv
rtl/i2c_master_byte_engine.sv
rtl/i2cm_checker.sv
bench/tb_i2c_master_byte_engine.sv
